@@ hw/rtl/vnr_pkg.sv @@
// shared types and constants for the vector normalize and rotate block
`default_nettype none

package vnr_pkg;

    // component format, signed Q1.F with F = COMP_WIDTH - 2
    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = COMP_WIDTH - 2;
    localparam int UNIT_VAL   = 1 << FRAC_BITS;
    localparam int UNIT_W     = FRAC_BITS + 1;
    localparam int SQ_W       = 2 * COMP_WIDTH - 1;
    localparam int SUM_W      = SQ_W + 1;

    // normalizer search
    localparam int NB          = UNIT_W;
    localparam int QSQ_W       = 2 * NB;
    localparam int DSQ_W       = 2 * NB + 2;
    localparam int PROD_W      = DSQ_W + SUM_W;
    localparam int RHS_SH      = 2 * FRAC_BITS + 2;
    localparam int NORM_STAGES = 2 * NB + 1;

    // angle handling, fixed 16-bit centidegrees
    localparam int ANG_W = 16;
    localparam int RED_W = 13;
    localparam logic [ANG_W-1:0] TURN_CD   = 16'd36000;
    localparam logic [ANG_W-1:0] THREEQ_CD = 16'd27000;
    localparam logic [ANG_W-1:0] HALF_CD   = 16'd18000;
    localparam logic [ANG_W-1:0] QTR_CD    = 16'd9000;
    localparam logic [ANG_W-1:0] OCT_CD    = 16'd4500;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // sine and cosine series in unsigned Q30
    localparam int Q30_W    = 30;
    localparam logic [Q30_W:0] Q30_ONE = 31'd1 << Q30_W;
    localparam logic [31:0] RAD_Q30 = 32'd187403;
    localparam int HORNER_N    = 5;
    localparam int TRIG_STAGES = 3 * HORNER_N + 4;
    localparam int TRIG_TAP    = NORM_STAGES - TRIG_STAGES - 1;
    localparam int OUT_SH      = Q30_W - FRAC_BITS;

    localparam logic [6:0] SIN_DIV [HORNER_N] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [6:0] COS_DIV [HORNER_N] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [30:0] SIN_RCP [HORNER_N] = '{
        31'd1249445031, 31'd1908874353, 31'd1636178017, 31'd1717986918, 31'd1431655765};
    localparam logic [30:0] COS_RCP [HORNER_N] = '{
        31'd1527099483, 31'd1227133513, 31'd1145324612, 31'd1431655765, 31'd1073741824};
    localparam int SIN_SH [HORNER_N] = '{37, 37, 36, 35, 33};
    localparam int COS_SH [HORNER_N] = '{37, 36, 35, 34, 31};

    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] vec_x;
        logic signed [COMP_WIDTH-1:0] vec_y;
        logic signed [COMP_WIDTH-1:0] vec_z;
        logic signed [ANG_W-1:0]      angle_centideg;
    } vec_t;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] rot_x;
        logic signed [COMP_WIDTH-1:0] rot_y;
        logic signed [COMP_WIDTH-1:0] rot_z;
        logic                         degenerate;
    } rot_t;

    // classified item between front and back
    typedef struct packed {
        logic [SQ_W-1:0]  sq_x;
        logic [SQ_W-1:0]  sq_y;
        logic [SQ_W-1:0]  sq_z;
        logic             neg_x;
        logic             neg_y;
        logic             neg_z;
        logic [RED_W-1:0] red;
        logic             swap;
        logic [1:0]       quad;
    } item_t;

endpackage

`default_nettype wire

@@ hw/rtl/vector_normalize_rotate_z.sv @@
// top level of the vector normalize and rotate-about-z block
`default_nettype none

// Takes one direction vector (signed Q1.14) and an angle in hundredths of a degree
// per beat, scales the vector to unit length and turns it about the z axis; rot_z is
// the unit z component, and an all-zero vector returns zeros with degenerate set.
// A new beat is accepted every clock while results are being taken. An accepted beat
// is registered in the front end, passes through the queue and then the back end,
// whose depth is set by the normalizer, which settles one result bit every two stages
// over 15 bits. A four-entry queue lets the front end keep taking beats while the
// result side stalls.

module vector_normalize_rotate_z (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           vec_valid,
    output logic                vec_ready,
    input  wire vnr_pkg::vec_t  vec,
    output logic                rot_valid,
    input  wire logic           rot_ready,
    output vnr_pkg::rot_t       rot
);

    logic           push_valid;
    logic           push_ready;
    vnr_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    vnr_pkg::item_t pop_item;

    vnr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vec_valid  (vec_valid),
        .vec_ready  (vec_ready),
        .vec        (vec),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    vnr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    vnr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .rot_valid (rot_valid),
        .rot_ready (rot_ready),
        .rot       (rot)
    );

endmodule

`default_nettype wire

@@ hw/rtl/vnr_front.sv @@
// front end: squares the components and folds the angle to an octant
`default_nettype none

module vnr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           vec_valid,
    output logic                vec_ready,
    input  wire vnr_pkg::vec_t  vec,
    output logic                push_valid,
    input  wire logic           push_ready,
    output vnr_pkg::item_t      push_item
);

    logic signed [2*vnr_pkg::COMP_WIDTH-1:0] px;
    logic signed [2*vnr_pkg::COMP_WIDTH-1:0] py;
    logic signed [2*vnr_pkg::COMP_WIDTH-1:0] pz;
    logic [vnr_pkg::ANG_W-1:0] ang_pos;
    logic [vnr_pkg::ANG_W-1:0] ang_base;
    logic [vnr_pkg::ANG_W-1:0] ang_rem;
    vnr_pkg::item_t            item;
    vnr_pkg::item_t            item_reg;
    logic                      vld_reg;

    assign px = vec.vec_x * vec.vec_x;
    assign py = vec.vec_y * vec.vec_y;
    assign pz = vec.vec_z * vec.vec_z;

    always_comb
    begin
        // negative angles wrap once into 0..35999
        ang_pos = vec.angle_centideg[vnr_pkg::ANG_W-1]
                ? vnr_pkg::ANG_W'(vec.angle_centideg) + vnr_pkg::TURN_CD
                : vnr_pkg::ANG_W'(vec.angle_centideg);
        item = '0;
        if (ang_pos >= vnr_pkg::THREEQ_CD)
        begin
            item.quad = vnr_pkg::QUAD_3;
            ang_base  = vnr_pkg::THREEQ_CD;
        end
        else if (ang_pos >= vnr_pkg::HALF_CD)
        begin
            item.quad = vnr_pkg::QUAD_2;
            ang_base  = vnr_pkg::HALF_CD;
        end
        else if (ang_pos >= vnr_pkg::QTR_CD)
        begin
            item.quad = vnr_pkg::QUAD_1;
            ang_base  = vnr_pkg::QTR_CD;
        end
        else
        begin
            item.quad = vnr_pkg::QUAD_0;
            ang_base  = '0;
        end
        ang_rem = ang_pos - ang_base;
        if (ang_rem > vnr_pkg::OCT_CD)
        begin
            item.red  = vnr_pkg::RED_W'(vnr_pkg::QTR_CD - ang_rem);
            item.swap = 1'b1;
        end
        else
        begin
            item.red  = vnr_pkg::RED_W'(ang_rem);
            item.swap = 1'b0;
        end
        item.sq_x  = px[vnr_pkg::SQ_W-1:0];
        item.sq_y  = py[vnr_pkg::SQ_W-1:0];
        item.sq_z  = pz[vnr_pkg::SQ_W-1:0];
        item.neg_x = vec.vec_x[vnr_pkg::COMP_WIDTH-1];
        item.neg_y = vec.vec_y[vnr_pkg::COMP_WIDTH-1];
        item.neg_z = vec.vec_z[vnr_pkg::COMP_WIDTH-1];
    end

    assign vec_ready  = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (vec_ready)
        begin
            vld_reg <= vec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec_ready && vec_valid)
        begin
            item_reg <= item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/vnr_fifo.sv @@
// short queue that decouples the front end from the back end
`default_nettype none

module vnr_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire vnr_pkg::item_t  push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output vnr_pkg::item_t       pop_item
);

    vnr_pkg::item_t                   mem_reg [vnr_pkg::FIFO_DEPTH];
    logic [vnr_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [vnr_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [vnr_pkg::FIFO_PTR_W:0]     count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = count_reg != (vnr_pkg::FIFO_PTR_W + 1)'(vnr_pkg::FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/vnr_norm.sv @@
// pipelined search for one rounded unit-vector magnitude, one bit per two stages
`default_nettype none

module vnr_norm (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [vnr_pkg::SQ_W-1:0]    sq,
    input  wire logic [vnr_pkg::SUM_W-1:0]   sum,
    output logic [vnr_pkg::UNIT_W-1:0]       q
);

    localparam int NB = vnr_pkg::NB;

    typedef struct packed {
        logic [NB-1:0]                q;
        logic [vnr_pkg::QSQ_W-1:0]    qsq;
        logic [NB-1:0]                c;
        logic [vnr_pkg::QSQ_W-1:0]    csq;
        logic [vnr_pkg::DSQ_W-1:0]    dsq;
        logic [vnr_pkg::SUM_W-1:0]    s;
        logic [vnr_pkg::SQ_W-1:0]     sq;
    } nst_t;

    nst_t st_reg [vnr_pkg::NORM_STAGES];
    nst_t st_in;

    always_comb
    begin
        st_in    = '0;
        st_in.s  = sum;
        st_in.sq = sq;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st_in;
        end
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_bit
        localparam int B = NB - 1 - k;
        nst_t                          a_in;
        nst_t                          b_in;
        logic [vnr_pkg::PROD_W-1:0]    prod;
        logic                          hit;

        // candidate c = q with bit B set, and (2c-1)^2 built from q^2 by adds
        always_comb
        begin
            a_in     = st_reg[2*k];
            a_in.c   = st_reg[2*k].q | (NB'(1) << B);
            a_in.csq = st_reg[2*k].qsq + (vnr_pkg::QSQ_W'(st_reg[2*k].q) << (B + 1))
                     + (vnr_pkg::QSQ_W'(1) << (2 * B));
            a_in.dsq = (vnr_pkg::DSQ_W'(a_in.csq) << 2) - (vnr_pkg::DSQ_W'(a_in.c) << 2)
                     + vnr_pkg::DSQ_W'(1);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[2*k+1] <= a_in;
            end
        end

        // keep the candidate while (2c-1)^2 * s <= v^2 * 4 * ONE^2
        assign prod = vnr_pkg::PROD_W'(st_reg[2*k+1].dsq) * vnr_pkg::PROD_W'(st_reg[2*k+1].s);
        assign hit  = prod <= (vnr_pkg::PROD_W'(st_reg[2*k+1].sq) << vnr_pkg::RHS_SH);

        always_comb
        begin
            b_in = st_reg[2*k+1];
            if (hit)
            begin
                b_in.q   = st_reg[2*k+1].c;
                b_in.qsq = st_reg[2*k+1].csq;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[2*k+2] <= b_in;
            end
        end
    end

    assign q = st_reg[vnr_pkg::NORM_STAGES-1].q;

endmodule

`default_nettype wire

@@ hw/rtl/vnr_trig.sv @@
// pipelined sine and cosine of an angle within one octant, series in Q30
`default_nettype none

module vnr_trig (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [vnr_pkg::RED_W-1:0]   red,
    output logic [vnr_pkg::UNIT_W-1:0]       sin_val,
    output logic [vnr_pkg::UNIT_W-1:0]       cos_val
);

    localparam int T_W  = vnr_pkg::Q30_W;
    localparam int P_W  = T_W + 1;
    localparam int M_W  = T_W + P_W;
    localparam int FIN  = 2 + 3 * vnr_pkg::HORNER_N;
    localparam logic [31:0] HALF_LSB = (32'd1 << vnr_pkg::OUT_SH) >> 1;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic [T_W-1:0] t2;
        logic [P_W-1:0] ps;
        logic [P_W-1:0] pc;
        logic [T_W-1:0] ns;
        logic [T_W-1:0] nc;
        logic [M_W-1:0] ms;
        logic [M_W-1:0] mc;
    } tst_t;

    tst_t                      st_reg [FIN+1];
    tst_t                      s0_in;
    tst_t                      s1_in;
    tst_t                      fin_in;
    logic [31:0]               t_full;
    logic [2*T_W-1:0]          tt;
    logic [M_W-1:0]            fs;
    logic [31:0]               sin_rnd;
    logic [31:0]               cos_rnd;
    logic [vnr_pkg::UNIT_W-1:0] sin_reg;
    logic [vnr_pkg::UNIT_W-1:0] cos_reg;

    assign t_full = 32'(red) * vnr_pkg::RAD_Q30;

    always_comb
    begin
        s0_in   = '0;
        s0_in.t = t_full[T_W-1:0];
    end

    assign tt = (2*T_W)'(st_reg[0].t) * (2*T_W)'(st_reg[0].t);

    always_comb
    begin
        s1_in    = st_reg[0];
        s1_in.t2 = tt[2*T_W-1:T_W];
        s1_in.ps = vnr_pkg::Q30_ONE;
        s1_in.pc = vnr_pkg::Q30_ONE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= s0_in;
            st_reg[1] <= s1_in;
        end
    end

    for (genvar i = 0; i < vnr_pkg::HORNER_N; i++)
    begin : g_term
        localparam int PA = 1 + 3 * i;
        tst_t           a_in;
        tst_t           b_in;
        tst_t           c_in;
        logic [M_W-1:0] ps_prod;
        logic [M_W-1:0] pc_prod;
        logic [T_W-1:0] qs0;
        logic [T_W-1:0] qc0;
        logic [T_W-1:0] rs;
        logic [T_W-1:0] rc;
        logic [T_W-1:0] qs;
        logic [T_W-1:0] qc;

        assign ps_prod = M_W'(st_reg[PA].t2) * M_W'(st_reg[PA].ps);
        assign pc_prod = M_W'(st_reg[PA].t2) * M_W'(st_reg[PA].pc);

        always_comb
        begin
            a_in    = st_reg[PA];
            a_in.ns = ps_prod[2*T_W-1:T_W];
            a_in.nc = pc_prod[2*T_W-1:T_W];
        end

        always_comb
        begin
            b_in    = st_reg[PA+1];
            b_in.ms = M_W'(st_reg[PA+1].ns) * M_W'(vnr_pkg::SIN_RCP[i]);
            b_in.mc = M_W'(st_reg[PA+1].nc) * M_W'(vnr_pkg::COS_RCP[i]);
        end

        // reciprocal quotient is low by at most one, fix it from the remainder
        assign qs0 = T_W'(st_reg[PA+2].ms >> vnr_pkg::SIN_SH[i]);
        assign qc0 = T_W'(st_reg[PA+2].mc >> vnr_pkg::COS_SH[i]);
        assign rs  = st_reg[PA+2].ns - T_W'(qs0 * T_W'(vnr_pkg::SIN_DIV[i]));
        assign rc  = st_reg[PA+2].nc - T_W'(qc0 * T_W'(vnr_pkg::COS_DIV[i]));
        assign qs  = qs0 + T_W'(rs >= T_W'(vnr_pkg::SIN_DIV[i]));
        assign qc  = qc0 + T_W'(rc >= T_W'(vnr_pkg::COS_DIV[i]));

        always_comb
        begin
            c_in    = st_reg[PA+2];
            c_in.ps = vnr_pkg::Q30_ONE - P_W'(qs);
            c_in.pc = vnr_pkg::Q30_ONE - P_W'(qc);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[PA+1] <= a_in;
                st_reg[PA+2] <= b_in;
                st_reg[PA+3] <= c_in;
            end
        end
    end

    assign fs = M_W'(st_reg[FIN-1].t) * M_W'(st_reg[FIN-1].ps);

    always_comb
    begin
        fin_in    = st_reg[FIN-1];
        fin_in.ps = P_W'(fs[2*T_W-1:T_W]);
    end

    assign sin_rnd = (32'(st_reg[FIN].ps) + HALF_LSB) >> vnr_pkg::OUT_SH;
    assign cos_rnd = (32'(st_reg[FIN].pc) + HALF_LSB) >> vnr_pkg::OUT_SH;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[FIN] <= fin_in;
            sin_reg     <= sin_rnd[vnr_pkg::UNIT_W-1:0];
            cos_reg     <= cos_rnd[vnr_pkg::UNIT_W-1:0];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

`default_nettype wire

@@ hw/rtl/vnr_back.sv @@
// back end: normalizer lanes, sine and cosine, rotation and result register
`default_nettype none

module vnr_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire vnr_pkg::item_t  pop_item,
    output logic                 rot_valid,
    input  wire logic            rot_ready,
    output vnr_pkg::rot_t        rot
);

    localparam int NS   = vnr_pkg::NORM_STAGES;
    localparam int UW   = vnr_pkg::UNIT_W;
    localparam int PR_W = 2 * UW + 2;
    localparam int CW   = vnr_pkg::COMP_WIDTH;

    typedef struct packed {
        logic                      neg_x;
        logic                      neg_y;
        logic                      neg_z;
        logic                      degen;
        logic                      swap;
        logic [1:0]                quad;
        logic [vnr_pkg::RED_W-1:0] red;
    } meta_t;

    function automatic logic signed [CW-1:0] round_sat(input logic signed [PR_W:0] p);
        logic [PR_W:0] mag;
        logic [PR_W:0] qv;
        logic [CW-1:0] qc;
        mag = p[PR_W] ? (PR_W + 1)'(-p) : (PR_W + 1)'(p);
        qv  = (mag + ((PR_W + 1)'(1) << (vnr_pkg::FRAC_BITS - 1))) >> vnr_pkg::FRAC_BITS;
        if (qv > (PR_W + 1)'(vnr_pkg::UNIT_VAL))
        begin
            qv = (PR_W + 1)'(vnr_pkg::UNIT_VAL);
        end
        qc = qv[CW-1:0];
        return p[PR_W] ? $signed(-qc) : $signed(qc);
    endfunction

    logic                         adv;
    meta_t                        head_meta;
    logic [vnr_pkg::SUM_W-1:0]    sum;
    meta_t                        meta_reg [NS];
    logic [NS-1:0]                vld_reg;
    logic [UW-1:0]                qx;
    logic [UW-1:0]                qy;
    logic [UW-1:0]                qz;
    logic [UW-1:0]                tsin;
    logic [UW-1:0]                tcos;
    logic [UW-1:0]                s0;
    logic [UW-1:0]                c0;
    logic signed [UW:0]           sp;
    logic signed [UW:0]           cp;
    logic signed [UW:0]           sn;
    logic signed [UW:0]           cs;
    logic signed [UW:0]           ux;
    logic signed [UW:0]           uy;
    logic signed [UW:0]           uz;
    logic signed [PR_W-1:0]       xc_reg;
    logic signed [PR_W-1:0]       ys_reg;
    logic signed [PR_W-1:0]       xs_reg;
    logic signed [PR_W-1:0]       yc_reg;
    logic signed [UW:0]           uz_reg;
    logic                         degen_reg;
    logic                         r0_vld_reg;
    logic signed [PR_W:0]         sum_x;
    logic signed [PR_W:0]         sum_y;
    vnr_pkg::rot_t                rot_next;
    vnr_pkg::rot_t                rot_reg;
    logic                         out_vld_reg;
    meta_t                        tail;

    // the whole pipe moves together unless a finished result is held
    assign adv       = !out_vld_reg || rot_ready;
    assign pop_ready = adv;

    assign sum = vnr_pkg::SUM_W'(pop_item.sq_x) + vnr_pkg::SUM_W'(pop_item.sq_y)
               + vnr_pkg::SUM_W'(pop_item.sq_z);

    always_comb
    begin
        head_meta       = '0;
        head_meta.neg_x = pop_item.neg_x;
        head_meta.neg_y = pop_item.neg_y;
        head_meta.neg_z = pop_item.neg_z;
        head_meta.degen = sum == '0;
        head_meta.swap  = pop_item.swap;
        head_meta.quad  = pop_item.quad;
        head_meta.red   = pop_item.red;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= head_meta;
            for (int i = 1; i < NS; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    vnr_norm u_norm_x (.clk(clk), .en(adv), .sq(pop_item.sq_x), .sum(sum), .q(qx));
    vnr_norm u_norm_y (.clk(clk), .en(adv), .sq(pop_item.sq_y), .sum(sum), .q(qy));
    vnr_norm u_norm_z (.clk(clk), .en(adv), .sq(pop_item.sq_z), .sum(sum), .q(qz));

    // tapped late so sine and cosine land with the normalized components
    vnr_trig u_trig (
        .clk     (clk),
        .en      (adv),
        .red     (meta_reg[vnr_pkg::TRIG_TAP].red),
        .sin_val (tsin),
        .cos_val (tcos)
    );

    assign tail = meta_reg[NS-1];

    always_comb
    begin
        s0 = tail.swap ? tcos : tsin;
        c0 = tail.swap ? tsin : tcos;
        sp = $signed({1'b0, s0});
        cp = $signed({1'b0, c0});
        sn = sp;
        cs = cp;
        unique case (tail.quad)
            vnr_pkg::QUAD_0:
            begin
                sn = sp;
                cs = cp;
            end
            vnr_pkg::QUAD_1:
            begin
                sn = cp;
                cs = -sp;
            end
            vnr_pkg::QUAD_2:
            begin
                sn = -sp;
                cs = -cp;
            end
            vnr_pkg::QUAD_3:
            begin
                sn = -cp;
                cs = sp;
            end
        endcase
        ux = tail.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        uy = tail.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        uz = tail.neg_z ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xc_reg    <= ux * cs;
            ys_reg    <= uy * sn;
            xs_reg    <= ux * sn;
            yc_reg    <= uy * cs;
            uz_reg    <= uz;
            degen_reg <= tail.degen;
        end
    end

    assign sum_x = (PR_W + 1)'(xc_reg) - (PR_W + 1)'(ys_reg);
    assign sum_y = (PR_W + 1)'(xs_reg) + (PR_W + 1)'(yc_reg);

    always_comb
    begin
        if (degen_reg)
        begin
            rot_next            = '0;
            rot_next.degenerate = 1'b1;
        end
        else
        begin
            rot_next.rot_x      = round_sat(sum_x);
            rot_next.rot_y      = round_sat(sum_y);
            rot_next.rot_z      = CW'(uz_reg);
            rot_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_reg <= rot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            r0_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NS-2:0], pop_valid};
            r0_vld_reg  <= vld_reg[NS-1];
            out_vld_reg <= r0_vld_reg;
        end
    end

    assign rot_valid = out_vld_reg;
    assign rot       = rot_reg;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// testbench for the vector normalize and rotate-about-z block
`timescale 1ns / 100ps

class rot_scoreboard;
    vnr_pkg::rot_t pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // unit component: largest q with (2q-1)^2 * s <= v^2 * 2^(2F+2)
    static function longint unit_comp(longint v, longint s);
        longint mag, lo, hi, mid, d;
        logic [127:0] lhs, rhs;
        mag = v < 0 ? -v : v;
        lo = 0;
        hi = vnr_pkg::UNIT_VAL;
        rhs = 128'(mag * mag) << (2 * vnr_pkg::FRAC_BITS + 2);
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            d = 2 * mid - 1;
            lhs = 128'(d * d) * 128'(s);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return v < 0 ? -lo : lo;
    endfunction

    static function longint q30_round(longint v);
        return (v + (64'd1 << (vnr_pkg::OUT_SH - 1))) >>> vnr_pkg::OUT_SH;
    endfunction

    // sine and cosine of 0..4500 centidegrees via truncated taylor series
    static function void octant_trig(longint r, output longint sn, output longint cs);
        longint sdiv[5] = '{110, 72, 42, 20, 6};
        longint cdiv[5] = '{90, 56, 30, 12, 2};
        longint t, t2, ps, pc;
        longint one;
        one = 64'd1 << 30;
        t = r * 187403;
        t2 = (t * t) >> 30;
        ps = one;
        pc = one;
        for (int i = 0; i < 5; i++)
        begin
            ps = one - ((t2 * ps) >> 30) / sdiv[i];
            pc = one - ((t2 * pc) >> 30) / cdiv[i];
        end
        sn = q30_round((t * ps) >> 30);
        cs = q30_round(pc);
    endfunction

    static function longint round_sat(longint p);
        longint mag, q;
        mag = p < 0 ? -p : p;
        q = (mag + (64'd1 << (vnr_pkg::FRAC_BITS - 1))) >> vnr_pkg::FRAC_BITS;
        if (q > vnr_pkg::UNIT_VAL)
            q = vnr_pkg::UNIT_VAL;
        return p < 0 ? -q : q;
    endfunction

    function void note_vec(vnr_pkg::vec_t v);
        longint x, y, z, s, ux, uy, uz, a, r, s0, c0, sn, cs;
        int quad;
        vnr_pkg::rot_t e;
        x = longint'(v.vec_x);
        y = longint'(v.vec_y);
        z = longint'(v.vec_z);
        s = x * x + y * y + z * z;
        e = '0;
        if (s == 0)
        begin
            e.degenerate = 1'b1;
            pending.push_back(e);
            return;
        end
        ux = unit_comp(x, s);
        uy = unit_comp(y, s);
        uz = unit_comp(z, s);
        a = longint'(v.angle_centideg) % 36000;
        if (a < 0)
            a += 36000;
        quad = int'(a / 9000);
        r = a % 9000;
        if (r <= 4500)
            octant_trig(r, s0, c0);
        else
            octant_trig(9000 - r, c0, s0);
        case (quad)
            0: begin sn = s0; cs = c0; end
            1: begin sn = c0; cs = -s0; end
            2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
        e.rot_x = 16'(round_sat(ux * cs - uy * sn));
        e.rot_y = 16'(round_sat(ux * sn + uy * cs));
        e.rot_z = 16'(uz);
        pending.push_back(e);
    endfunction

    function void check_rot(vnr_pkg::rot_t got);
        vnr_pkg::rot_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result beat %h", got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.rot_x !== e.rot_x)
        begin
            $error("rot_x expected %0d got %0d", e.rot_x, got.rot_x);
            errors++;
        end
        if (got.rot_y !== e.rot_y)
        begin
            $error("rot_y expected %0d got %0d", e.rot_y, got.rot_y);
            errors++;
        end
        if (got.rot_z !== e.rot_z)
        begin
            $error("rot_z expected %0d got %0d", e.rot_z, got.rot_z);
            errors++;
        end
        if (got.degenerate !== e.degenerate)
        begin
            $error("degenerate expected %0d got %0d", e.degenerate, got.degenerate);
            errors++;
        end
    endfunction
endclass

module tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic vec_valid = 1'b0;
    logic vec_ready;
    vnr_pkg::vec_t vec = '0;
    logic rot_valid;
    logic rot_ready = 1'b0;
    vnr_pkg::rot_t rot;
    bit inputs_done = 0;

    rot_scoreboard board = new();

    vector_normalize_rotate_z u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_valid (vec_valid),
        .vec_ready (vec_ready),
        .vec       (vec),
        .rot_valid (rot_valid),
        .rot_ready (rot_ready),
        .rot       (rot)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_beat(vnr_pkg::vec_t v);
        vec <= v;
        vec_valid <= 1'b1;
        do
            @(posedge clk);
        while (!vec_ready);
        board.note_vec(v);
    endtask

    task automatic idle_send(int n);
        if (n > 0)
        begin
            vec_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_comp();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 16'sh8000;
        if (p == 1)
            return 16'sh7fff;
        if (p == 2)
            return 16'($signed($urandom_range(0, 8)) - 4);
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_angle();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 16'($urandom);
        if (p == 1)
            return 16'(($signed($urandom_range(0, 8)) - 4) * 4500);
        return 16'($signed($urandom_range(0, 36000)) - 18000);
    endfunction

    initial
    begin
        vnr_pkg::vec_t v;
        int dir_ang[12] = '{0, 4500, 4501, 9000, 13500, 18000, -18000, -9000,
                            -4500, -1, 32767, -32768};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // zero vector, extremes and octant boundaries
        send_beat('{16'sd0, 16'sd0, 16'sd0, 16'sd1000});
        send_beat('{16'sh8000, 16'sh8000, 16'sh8000, 16'sd18000});
        send_beat('{16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sd18000});
        send_beat('{16'sh8000, 16'sd0, 16'sd0, 16'sd9000});
        send_beat('{16'sd0, 16'sd0, 16'sd1, 16'sd0});
        send_beat('{16'sd0, -16'sd1, 16'sd0, 16'sd0});
        foreach (dir_ang[i])
        begin
            send_beat('{16'sd16384, 16'sd3, -16'sd7, 16'(dir_ang[i])});
            idle_send(i % 3);
        end
        for (int n = 0; n < 1500; n++)
        begin
            v.vec_x = rand_comp();
            v.vec_y = rand_comp();
            v.vec_z = rand_comp();
            v.angle_centideg = rand_angle();
            if ($urandom_range(0, 49) == 0)
                v = '{16'sd0, 16'sd0, 16'sd0, v.angle_centideg};
            send_beat(v);
            if (n % 300 < 200)
                idle_send(gap_len());
        end
        vec_valid <= 1'b0;
        inputs_done = 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && rot_valid && rot_ready)
            board.check_rot(rot);
    end

    initial
    begin
        int k;
        int n;
        k = 0;
        forever
        begin
            @(posedge clk);
            k++;
            if ((k / 500) % 3 == 0)
                rot_ready <= 1'b1;
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    rot_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                    k += n;
                end
                rot_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (inputs_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end
endmodule
